// ===== rtl/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// shared sizes, status codes and opcodes for the syscall latency aggregator
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int START_ENTRIES = 1024;
  localparam int STAT_ENTRIES  = 1024;
  localparam int START_AW      = $clog2(START_ENTRIES);
  localparam int STAT_AW       = $clog2(STAT_ENTRIES);
  localparam int OWNER_W       = 64;
  localparam int KEY_W         = 41;
  localparam int TIME_W        = 64;

  // clearing pass length and scan index width
  localparam int CLR_N = (START_ENTRIES > STAT_ENTRIES) ? START_ENTRIES : STAT_ENTRIES;
  localparam int CW    = $clog2(CLR_N + 2);

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_CREATED  = 3'd2;
  localparam logic [2:0] ST_NO_START = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_EXIT  = 1'b1;

  // start table word: valid, owner, time
  localparam int START_W = 1 + OWNER_W + TIME_W;
  // bucket word: valid, key, count, total, peak
  localparam int STAT_W  = 1 + KEY_W + 3 * TIME_W;

endpackage

// ===== rtl/syscall_latency_aggregator.sv =====
// ----------------------------------------------------------------------------
// syscall_latency_aggregator
// pairs syscall enter and exit beats, keeps per-process per-syscall stats
// ----------------------------------------------------------------------------
// after reset a clearing pass holds busy high while it clears every entry of both
// tables. each beat scans its table one entry per cycle through the single ram
// port: an enter or an unmatched exit scans only the start table, a matched exit
// scans the start table and then the bucket table. done pulses in the same cycle
// that busy falls, and the next beat can be taken in the done cycle. the receiver
// cannot stall
module syscall_latency_aggregator
  import sla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] process_id,
  input  logic [31:0] thread_id,
  input  logic [63:0] timestamp_ns,
  input  logic [8:0]  call_nr,
  output logic        done,
  output logic [2:0]  status,
  output logic [63:0] latency_ns,
  output logic [63:0] call_count,
  output logic [63:0] sum_ns,
  output logic [63:0] max_latency_ns
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SSCAN, S_SWAIT, S_SWR, S_BSCAN, S_BWAIT, S_BWR, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] idx;
  logic [CW-1:0] ridx;
  logic          rd_live;
  logic          op_r;
  logic [OWNER_W-1:0] owner_r;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  ts_r;
  logic               hit_f, free_f;
  logic [CW-1:0]      hit_a, free_a;
  logic [TIME_W-1:0]  time_h, lat_r;
  logic [TIME_W-1:0]  cnt_h, tot_h, peak_h;

  logic               s_we, b_we;
  logic [START_AW-1:0] s_addr;
  logic [STAT_AW-1:0]  b_addr;
  logic [START_W-1:0] s_wd, s_rd;
  logic [STAT_W-1:0]  b_wd, b_rd;

  logic [TIME_W-1:0] cnt_n, tot_n, peak_n;

  sla_ram #(.WIDTH(START_W), .DEPTH(START_ENTRIES)) u_start (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  sla_ram #(.WIDTH(STAT_W), .DEPTH(STAT_ENTRIES)) u_stat (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));

  assign busy = (state != S_IDLE);

  always_comb begin
    s_we   = 1'b0;
    b_we   = 1'b0;
    s_addr = idx[START_AW-1:0];
    b_addr = idx[STAT_AW-1:0];
    s_wd   = '0;
    b_wd   = '0;
    cnt_n  = cnt_h + 64'd1;
    tot_n  = tot_h + lat_r;
    peak_n = (lat_r > peak_h) ? lat_r : peak_h;
    case (state)
      S_CLEAR: begin
        s_we = (idx < CW'(START_ENTRIES));
        b_we = (idx < CW'(STAT_ENTRIES));
      end
      S_SWR: begin
        if (op_r == OP_ENTER) begin
          s_we   = hit_f || free_f;
          s_addr = hit_f ? hit_a[START_AW-1:0] : free_a[START_AW-1:0];
          s_wd   = {1'b1, owner_r, ts_r};
        end else begin
          s_we   = hit_f;
          s_addr = hit_a[START_AW-1:0];
          s_wd   = '0;
        end
      end
      S_BWR: begin
        b_we = hit_f || free_f;
        if (hit_f) begin
          b_addr = hit_a[STAT_AW-1:0];
          b_wd   = {1'b1, key_r, cnt_n, tot_n, peak_n};
        end else begin
          b_addr = free_a[STAT_AW-1:0];
          b_wd   = {1'b1, key_r, 64'd1, lat_r, lat_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      idx     <= '0;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (idx == CW'(CLR_N - 1)) begin
            state <= S_IDLE;
            idx   <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= opcode;
            owner_r <= {process_id, thread_id};
            key_r   <= {process_id, call_nr};
            ts_r    <= timestamp_ns;
            hit_f   <= 1'b0;
            free_f  <= 1'b0;
            idx     <= '0;
            rd_live <= 1'b0;
            state   <= S_SSCAN;
          end
        end
        S_SSCAN, S_SWAIT: begin
          // examine the word read last cycle
          if (rd_live && !hit_f) begin
            if (s_rd[START_W-1]) begin
              if (s_rd[START_W-2 -: OWNER_W] == owner_r) begin
                hit_f  <= 1'b1;
                hit_a  <= ridx;
                time_h <= s_rd[TIME_W-1:0];
              end
            end else if (!free_f) begin
              free_f <= 1'b1;
              free_a <= ridx;
            end
          end
          ridx <= idx;
          if (state == S_SSCAN) begin
            rd_live <= 1'b1;
            if (idx == CW'(START_ENTRIES - 1)) state <= S_SWAIT;
            else idx <= idx + CW'(1);
          end else begin
            rd_live <= 1'b0;
            state   <= S_SWR;
          end
        end
        S_SWR: begin
          lat_r <= ts_r - time_h;
          if (op_r == OP_ENTER) begin
            status         <= (hit_f || free_f) ? ST_STORED : ST_FULL;
            latency_ns     <= '0;
            call_count     <= '0;
            sum_ns         <= '0;
            max_latency_ns <= '0;
            state          <= S_OUT;
          end else if (!hit_f) begin
            status         <= ST_NO_START;
            latency_ns     <= '0;
            call_count     <= '0;
            sum_ns         <= '0;
            max_latency_ns <= '0;
            state          <= S_OUT;
          end else begin
            hit_f   <= 1'b0;
            free_f  <= 1'b0;
            idx     <= '0;
            rd_live <= 1'b0;
            state   <= S_BSCAN;
          end
        end
        S_BSCAN, S_BWAIT: begin
          if (rd_live && !hit_f) begin
            if (b_rd[STAT_W-1]) begin
              if (b_rd[STAT_W-2 -: KEY_W] == key_r) begin
                hit_f  <= 1'b1;
                hit_a  <= ridx;
                cnt_h  <= b_rd[3*TIME_W-1 -: TIME_W];
                tot_h  <= b_rd[2*TIME_W-1 -: TIME_W];
                peak_h <= b_rd[TIME_W-1:0];
              end
            end else if (!free_f) begin
              free_f <= 1'b1;
              free_a <= ridx;
            end
          end
          ridx <= idx;
          if (state == S_BSCAN) begin
            rd_live <= 1'b1;
            if (idx == CW'(STAT_ENTRIES - 1)) state <= S_BWAIT;
            else idx <= idx + CW'(1);
          end else begin
            rd_live <= 1'b0;
            state   <= S_BWR;
          end
        end
        S_BWR: begin
          latency_ns <= lat_r;
          if (hit_f) begin
            status         <= ST_UPDATED;
            call_count     <= cnt_n;
            sum_ns         <= tot_n;
            max_latency_ns <= peak_n;
          end else if (free_f) begin
            status         <= ST_CREATED;
            call_count     <= 64'd1;
            sum_ns         <= lat_r;
            max_latency_ns <= lat_r;
          end else begin
            status         <= ST_FULL;
            call_count     <= '0;
            sum_ns         <= '0;
            max_latency_ns <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sla_ram.sv =====
// ----------------------------------------------------------------------------
// sla_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== tb/sv/syscall_latency_aggregator_tb.sv =====
// ----------------------------------------------------------------------------
// syscall_latency_aggregator_tb
// drives enter and exit beats into the aggregator and checks every result
// against a model built on associative arrays: edge values, unmatched exits,
// overwritten starts, total wrap and random paired traffic
// ----------------------------------------------------------------------------
module syscall_latency_aggregator_tb;
  import sla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic        op;
    logic [31:0] pid;
    logic [31:0] tid;
    logic [63:0] ts;
    logic [8:0]  nr;
  } event_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [63:0] lat;
    logic [63:0] cnt;
    logic [63:0] tot;
    logic [63:0] peak;
  } stats_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [31:0] process_id;
  logic [31:0] thread_id;
  logic [63:0] timestamp_ns;
  logic [8:0]  call_nr;
  logic        done;
  logic [2:0]  status;
  logic [63:0] latency_ns;
  logic [63:0] call_count;
  logic [63:0] sum_ns;
  logic [63:0] max_latency_ns;

  syscall_latency_aggregator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .process_id(process_id), .thread_id(thread_id),
    .timestamp_ns(timestamp_ns), .call_nr(call_nr),
    .done(done), .status(status), .latency_ns(latency_ns),
    .call_count(call_count), .sum_ns(sum_ns),
    .max_latency_ns(max_latency_ns)
  );

  // model state: pending starts by thread identity, buckets by {pid, nr}
  logic [63:0] pending_start [logic [63:0]];
  logic [63:0] bkt_count [logic [40:0]];
  logic [63:0] bkt_total [logic [40:0]];
  logic [63:0] bkt_peak  [logic [40:0]];

  event_t      event_queue [$];
  stats_t      expected_stats [$];
  event_t      cur_event;
  int          gap_left;
  int          beats_sent = 0;
  int          mismatches = 0;
  longint      cycles;
  bit          stim_done = 1'b0;

  function automatic stats_t apply_event(event_t e);
    stats_t      r;
    logic [63:0] owner;
    logic [40:0] key;
    r = '0;
    owner = {e.pid, e.tid};
    if (e.op == OP_ENTER) begin
      if (!pending_start.exists(owner) && pending_start.num() >= START_ENTRIES) begin
        r.st = ST_FULL;
      end else begin
        pending_start[owner] = e.ts;
        r.st = ST_STORED;
      end
    end else if (!pending_start.exists(owner)) begin
      r.st = ST_NO_START;
    end else begin
      r.lat = e.ts - pending_start[owner];
      pending_start.delete(owner);
      key = {e.pid, e.nr};
      if (bkt_count.exists(key)) begin
        bkt_count[key] = bkt_count[key] + 64'd1;
        bkt_total[key] = bkt_total[key] + r.lat;
        if (r.lat > bkt_peak[key]) bkt_peak[key] = r.lat;
        r.st = ST_UPDATED;
      end else if (bkt_count.num() < STAT_ENTRIES) begin
        bkt_count[key] = 64'd1;
        bkt_total[key] = r.lat;
        bkt_peak[key]  = r.lat;
        r.st = ST_CREATED;
      end else begin
        r.st = ST_FULL;
      end
      if (r.st != ST_FULL) begin
        r.cnt  = bkt_count[key];
        r.tot  = bkt_total[key];
        r.peak = bkt_peak[key];
      end
    end
    return r;
  endfunction

  function automatic event_t mk(logic op, logic [31:0] pid, logic [31:0] tid,
                                logic [63:0] ts, logic [8:0] nr);
    event_t e;
    e.op = op; e.pid = pid; e.tid = tid; e.ts = ts; e.nr = nr;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus
  initial begin
    logic [31:0] pids [4];
    logic [31:0] tids [4];
    logic [8:0]  nrs  [3];
    logic [63:0] base;
    int          p, t, k;

    // edge values and named special cases
    event_queue.push_back(mk(OP_ENTER, 32'h0, 32'h0, 64'h0, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h0, 32'h0, 64'h0, 9'h0));
    event_queue.push_back(mk(OP_ENTER, '1, '1, '1, 9'h1FF));
    event_queue.push_back(mk(OP_EXIT,  '1, '1, 64'h0, 9'h1FF));
    event_queue.push_back(mk(OP_EXIT,  32'h5, 32'h6, 64'h100, 9'h3));
    event_queue.push_back(mk(OP_ENTER, 32'h7, 32'h8, 64'h10, 9'h55));
    event_queue.push_back(mk(OP_ENTER, 32'h7, 32'h8, 64'h20, 9'h1AA));
    event_queue.push_back(mk(OP_EXIT,  32'h7, 32'h8, 64'h30, 9'h4));
    event_queue.push_back(mk(OP_EXIT,  32'h7, 32'h8, 64'h40, 9'h4));
    event_queue.push_back(mk(OP_ENTER, 32'h7, 32'h9, 64'h0, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h7, 32'h9, 64'h5, 9'h4));
    event_queue.push_back(mk(OP_ENTER, 32'h7, 32'hA, 64'h0, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h7, 32'hA, 64'h50, 9'h4));
    // total wrap
    event_queue.push_back(mk(OP_ENTER, 32'h9, 32'h1, 64'h0, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h9, 32'h1, '1, 9'h7));
    event_queue.push_back(mk(OP_ENTER, 32'h9, 32'h1, 64'h1, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h9, 32'h1, '1, 9'h7));
    event_queue.push_back(mk(OP_ENTER, 32'h9, 32'h2, 64'h8000_0000_0000_0000, 9'h0));
    event_queue.push_back(mk(OP_EXIT,  32'h9, 32'h2, 64'h0, 9'h7));

    // random part: paired sequences over small pools, with noise
    for (int i = 0; i < 4; i++) begin
      pids[i] = $urandom;
      tids[i] = $urandom;
    end
    for (int i = 0; i < 3; i++) nrs[i] = 9'($urandom_range(0, 511));
    while (event_queue.size() < 450) begin
      k = $urandom_range(0, 99);
      p = $urandom_range(0, 3);
      t = $urandom_range(0, 3);
      base = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom);
      if (k < 70) begin
        event_queue.push_back(mk(OP_ENTER, pids[p], tids[t], base,
                                 9'($urandom_range(0, 511))));
        event_queue.push_back(mk(OP_EXIT, pids[p], tids[t],
          ($urandom_range(0, 5) == 0) ? rand64() : base + 64'($urandom_range(0, 5000)),
          ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                      : nrs[$urandom_range(0, 2)]));
      end else if (k < 85) begin
        event_queue.push_back(mk(1'($urandom_range(0, 1)), pids[p], tids[t], rand64(),
                                 9'($urandom_range(0, 511))));
      end else begin
        event_queue.push_back(mk(1'($urandom_range(0, 1)), $urandom, $urandom, rand64(),
                                 9'($urandom_range(0, 511))));
      end
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    event_t nxt;
    logic   nxt_start;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
      gap_left  = 0;
      opcode       <= OP_ENTER;
      process_id   <= '0;
      thread_id    <= '0;
      timestamp_ns <= '0;
      call_nr      <= '0;
    end else begin
      if (start && !busy) begin
        expected_stats.push_back(apply_event(cur_event));
        beats_sent++;
        nxt_start = 1'b0;
        gap_left  = ((beats_sent / 60) % 3 == 2) ? 0 : pick_gap();
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_queue.size() > 0) begin
          nxt = event_queue.pop_front();
          cur_event    = nxt;
          opcode       <= nxt.op;
          process_id   <= nxt.pid;
          thread_id    <= nxt.tid;
          timestamp_ns <= nxt.ts;
          call_nr      <= nxt.nr;
          nxt_start    = 1'b1;
        end
      end
    end
    start <= nxt_start;
  end

  // monitor
  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && done) begin
      got = {status, latency_ns, call_count, sum_ns, max_latency_ns};
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch st %0d/%0d lat %h/%h cnt %h/%h tot %h/%h max %h/%h",
                     want.st, got.st, want.lat, got.lat, want.cnt, got.cnt,
                     want.tot, got.tot, want.peak, got.peak);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (rst || event_queue.size() != 0 || start !== 1'b0 || expected_stats.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== syscall_latency_aggregator.f =====
rtl/sla_pkg.sv
rtl/sla_ram.sv
rtl/syscall_latency_aggregator.sv
tb/sv/syscall_latency_aggregator_tb.sv
